[hdl/pcpc_pkg.sv]
// Package: constants, codes and state type of the polygon cut particle classifier.
`timescale 1ns / 1ps
`default_nettype none

package pcpc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int NUM_POLYGONS = 6;
    localparam int NUM_COUNTS   = 6;
    localparam int STORE_DEPTH  = NUM_POLYGONS * MAX_VERTICES;

    localparam int VTX_IDX_W = $clog2(MAX_VERTICES);
    localparam int POLY_W    = $clog2(NUM_POLYGONS);
    localparam int ADDR_W    = POLY_W + VTX_IDX_W;
    localparam int COUNT_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 6;
    localparam int ENERGY_W  = 16;
    localparam int VERTEX_W  = 2 * ENERGY_W;
    localparam int CLASS_W   = 2;
    localparam int PROD_W    = 2 * (ENERGY_W + 1);

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] LAST_PARTICLE = 2'd2;
    localparam logic [POLY_W-1:0] ALT_BASE = POLY_W'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POLY,
        ST_RUN,
        ST_DRAIN,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

[hdl/pcpc_if.sv]
// Interfaces: hit/load input channel and class output channel.
`timescale 1ns / 1ps
`default_nettype none

interface pcpc_in_if
    import pcpc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic                alt_set;
    logic [ENERGY_W-1:0] stop_energy;
    logic [ENERGY_W-1:0] thin_energy;
    logic [2:0]          polygon_sel;
    logic [4:0]          vertex_index;
    logic [ENERGY_W-1:0] vertex_stop;
    logic [ENERGY_W-1:0] vertex_thin;

    modport source (output valid, cmd, alt_set, stop_energy, thin_energy, polygon_sel,
                    vertex_index, vertex_stop, vertex_thin, input ready);
    modport sink   (input valid, cmd, alt_set, stop_energy, thin_energy, polygon_sel,
                    vertex_index, vertex_stop, vertex_thin, output ready);
endinterface

interface pcpc_out_if
    import pcpc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] particle_class;

    modport source (output valid, particle_class, input ready);
    modport sink   (input valid, particle_class, output ready);
endinterface

`default_nettype wire

[hdl/polygon_cut_particle_classifier_unit.sv]
// Top level: delta-E/E particle classifier with polygon cuts held in a vertex memory.
`timescale 1ns / 1ps
`default_nettype none

// Classifies a hit (stopping energy Q8.8, thin energy Q4.12) against the proton,
// deuteron and triton polygons of the selected set, with the even-odd crossing rule,
// and returns 0 for none or 1..3. A load beat writes one vertex. A classify beat
// walks the vertex memory one vertex per cycle through its single read port, one
// polygon after another (n vertices, n clamped to 32); a polygon of zero vertices
// is skipped. Only one hit is in work at a time; the next beat is taken as soon as
// the result sits in the output register. Vertices must be loaded before the
// polygons that use them are tested; the memory is not cleared.
module polygon_cut_particle_classifier_unit
    import pcpc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    pcpc_in_if.sink                    in_ch,
    pcpc_out_if.source                 out_ch
);

    state_t state_reg, state_next;
    logic [POLY_W-1:0]  poly_reg, poly_next;
    logic [1:0]         pidx_reg, pidx_next;
    logic [COUNT_W-1:0] step_reg, step_next;
    logic [COUNT_W-1:0] nvert_reg, nvert_next;
    logic [CLASS_W-1:0] res_class_reg, res_class_next;
    logic               out_valid_reg, out_valid_next;
    logic [CLASS_W-1:0] out_class_reg;

    logic [COUNT_W-1:0]  counts_reg [NUM_COUNTS];
    logic [ENERGY_W-1:0] hit_stop_reg;
    logic [ENERGY_W-1:0] hit_thin_reg;

    logic [VERTEX_W-1:0] store_mem [STORE_DEPTH];
    logic                rd_en;
    logic                rd_first;
    logic                rd_last;
    logic [ADDR_W-1:0]   rd_addr;
    logic [VTX_IDX_W-1:0] rd_idx;
    logic [VERTEX_W-1:0] rd_data_reg;
    logic                rd_vld_reg, rd_first_reg, rd_last_reg;
    logic [VERTEX_W-1:0] prev_reg;

    logic                       e_vld_reg, e_last_reg, spans_reg, dypos_reg;
    logic signed [PROD_W-1:0]   lhs_reg, rhs_reg;
    logic                       odd_reg, done_reg, inside_reg;

    logic                in_acc;
    logic                out_load;
    logic [COUNT_W-1:0]  cnt_raw;
    logic [COUNT_W-1:0]  cnt_clamp;

    logic [ENERGY_W-1:0]      xi, yi, xj, yj;
    logic                     spans;
    logic signed [ENERGY_W:0] dy_s, dx_s, ry_s, rx_s;
    logic                     below;
    logic                     toggle;

    assign in_acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.particle_class = out_class_reg;

    assign cnt_raw = counts_reg[poly_reg];
    assign cnt_clamp = (cnt_raw > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES) : cnt_raw;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COUNTS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_COUNTS)))
        begin
            counts_reg[cfg_index] <= cfg_data;
        end
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            poly_reg      <= '0;
            pidx_reg      <= '0;
            step_reg      <= '0;
            nvert_reg     <= '0;
            res_class_reg <= CLASS_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            poly_reg      <= poly_next;
            pidx_reg      <= pidx_next;
            step_reg      <= step_next;
            nvert_reg     <= nvert_next;
            res_class_reg <= res_class_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        poly_next      = poly_reg;
        pidx_next      = pidx_reg;
        step_next      = step_reg;
        nvert_next     = nvert_reg;
        res_class_next = res_class_reg;
        rd_en          = 1'b0;
        rd_first       = 1'b0;
        rd_last        = 1'b0;
        rd_idx         = '0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_ch.cmd == CMD_CLASSIFY))
                begin
                    poly_next  = in_ch.alt_set ? ALT_BASE : '0;
                    pidx_next  = '0;
                    state_next = ST_POLY;
                end
            end
            ST_POLY:
            begin
                if (cnt_clamp == '0)
                begin
                    if (pidx_reg == LAST_PARTICLE)
                    begin
                        res_class_next = CLASS_NONE;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        poly_next = poly_reg + POLY_W'(1);
                        pidx_next = pidx_reg + 2'd1;
                    end
                end
                else
                begin
                    nvert_next = cnt_clamp;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // step 0 fetches the closing vertex, then vertices 0..n-1
                rd_en    = 1'b1;
                rd_first = (step_reg == '0);
                rd_last  = (step_reg == nvert_reg);
                rd_idx   = rd_first ? VTX_IDX_W'(nvert_reg - COUNT_W'(1))
                                    : VTX_IDX_W'(step_reg - COUNT_W'(1));
                step_next = step_reg + COUNT_W'(1);
                if (rd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (done_reg)
                begin
                    if (inside_reg)
                    begin
                        res_class_next = CLASS_W'(pidx_reg) + CLASS_W'(1);
                        state_next     = ST_FIN;
                    end
                    else if (pidx_reg == LAST_PARTICLE)
                    begin
                        res_class_next = CLASS_NONE;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        poly_next  = poly_reg + POLY_W'(1);
                        pidx_next  = pidx_reg + 2'd1;
                        state_next = ST_POLY;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rd_addr = {poly_reg, rd_idx};

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_class_reg <= res_class_reg;
        end
        if (in_acc && (in_ch.cmd == CMD_CLASSIFY))
        begin
            hit_stop_reg <= in_ch.stop_energy;
            hit_thin_reg <= in_ch.thin_energy;
        end
    end

    // vertex memory
    always_ff @(posedge clk)
    begin
        if (in_acc && (in_ch.cmd == CMD_LOAD) && (in_ch.polygon_sel < POLY_W'(NUM_POLYGONS)))
        begin
            store_mem[{in_ch.polygon_sel, in_ch.vertex_index}] <=
                {in_ch.vertex_stop, in_ch.vertex_thin};
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // edge stage: crossing test and cross products
    always_comb
    begin
        xi    = rd_data_reg[VERTEX_W-1:ENERGY_W];
        yi    = rd_data_reg[ENERGY_W-1:0];
        xj    = prev_reg[VERTEX_W-1:ENERGY_W];
        yj    = prev_reg[ENERGY_W-1:0];
        spans = ((yi < hit_thin_reg) && (yj >= hit_thin_reg)) ||
                ((yj < hit_thin_reg) && (yi >= hit_thin_reg));
        dy_s  = $signed({1'b0, yj}) - $signed({1'b0, yi});
        dx_s  = $signed({1'b0, xj}) - $signed({1'b0, xi});
        ry_s  = $signed({1'b0, hit_thin_reg}) - $signed({1'b0, yi});
        rx_s  = $signed({1'b0, hit_stop_reg}) - $signed({1'b0, xi});
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prev_reg  <= rd_data_reg;
            spans_reg <= spans;
            dypos_reg <= (yj > yi);
            lhs_reg   <= PROD_W'(ry_s) * PROD_W'(dx_s);
            rhs_reg   <= PROD_W'(rx_s) * PROD_W'(dy_s);
        end
    end

    assign below  = dypos_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);
    assign toggle = e_vld_reg && spans_reg && below;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            e_vld_reg    <= 1'b0;
            e_last_reg   <= 1'b0;
            odd_reg      <= 1'b0;
            done_reg     <= 1'b0;
            inside_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= rd_en;
            rd_first_reg <= rd_first;
            rd_last_reg  <= rd_last;
            e_vld_reg    <= rd_vld_reg && !rd_first_reg;
            e_last_reg   <= rd_vld_reg && rd_last_reg;
            done_reg     <= e_vld_reg && e_last_reg;
            inside_reg   <= odd_reg ^ toggle;
            if (state_reg == ST_POLY)
            begin
                odd_reg <= 1'b0;
            end
            else if (toggle)
            begin
                odd_reg <= !odd_reg;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/pcpc_checker.sv]
// Checker: port-level properties of the classifier and its bind.
`timescale 1ns / 1ps
`default_nettype none

module pcpc_checker
    import pcpc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               in_cmd,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [CLASS_W-1:0] particle_class
);

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(particle_class))
        else $error("output beat dropped or changed while stalled");

    // a classify beat occupies the unit
    a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_CLASSIFY) |=> !in_ready)
        else $error("input ready after a classify beat");

    // a load beat leaves the unit ready
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_LOAD) |=> in_ready)
        else $error("unit busy after a load beat");

    // results only appear while a classify is in work
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result beat without a classify in work");

endmodule

bind polygon_cut_particle_classifier_unit pcpc_checker u_pcpc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_cmd         (in_ch.cmd),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .particle_class (out_ch.particle_class)
);

`default_nettype wire

[verif/pcpc_class_checker.sv]
// Checker: tracks vertex memory and counts, predicts particle class per hit, compares results.
`timescale 1ns / 1ps

module pcpc_class_checker
    import pcpc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    pcpc_in_if                         in_ch,
    pcpc_out_if                        out_ch,
    output int                         classes_due,
    output int                         fail_count
);

    localparam int SET_SIZE   = 3;
    localparam int SHOW_LIMIT = 10;

    typedef enum logic [CLASS_W-1:0] {
        PART_NONE,
        PART_PROTON,
        PART_DEUTERON,
        PART_TRITON
    } particle_e;

    logic [VERTEX_W-1:0] vertex_ram [STORE_DEPTH];
    logic [COUNT_W-1:0]  poly_len [NUM_COUNTS];
    particle_e           pending_classes [$];
    int                  errs = 0;

    // even-odd crossing test, exact compare of the edge intercept by cross-multiplying
    function automatic logic hit_in_polygon(int p, logic [ENERGY_W-1:0] px,
                                            logic [ENERGY_W-1:0] py);
        int n;
        int j;
        logic odd;
        longint xi, yi, xj, yj, x, y, dy, lhs, rhs;
        logic [VERTEX_W-1:0] vi, vj;
        odd = 1'b0;
        if (p >= NUM_POLYGONS || p >= NUM_COUNTS)
            return 1'b0;
        n = int'(poly_len[p]);
        if (n > MAX_VERTICES)
            n = MAX_VERTICES;
        if (n == 0)
            return 1'b0;
        x = longint'(px);
        y = longint'(py);
        j = n - 1;
        for (int i = 0; i < n; i++)
        begin
            vi = vertex_ram[p * MAX_VERTICES + i];
            vj = vertex_ram[p * MAX_VERTICES + j];
            xi = longint'(vi[VERTEX_W-1:ENERGY_W]);
            yi = longint'(vi[ENERGY_W-1:0]);
            xj = longint'(vj[VERTEX_W-1:ENERGY_W]);
            yj = longint'(vj[ENERGY_W-1:0]);
            if ((yi < y && yj >= y) || (yj < y && yi >= y))
            begin
                dy  = yj - yi;
                lhs = (y - yi) * (xj - xi);
                rhs = (x - xi) * dy;
                if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
                    odd = ~odd;
            end
            j = i;
        end
        return odd;
    endfunction

    function automatic particle_e classify_hit(logic alt, logic [ENERGY_W-1:0] px,
                                               logic [ENERGY_W-1:0] py);
        int base;
        base = alt ? int'(ALT_BASE) : 0;
        for (int k = 0; k < SET_SIZE; k++)
        begin
            if (hit_in_polygon(base + k, px, py))
                return particle_e'(k + 1);
        end
        return PART_NONE;
    endfunction

    task automatic flag_bad(input string what, input int want, input int got);
        errs++;
        if (errs <= SHOW_LIMIT)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        particle_e want;
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_COUNTS; r++)
                poly_len[r] = '0;
            pending_classes.delete();
            classes_due <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (cfg_we && int'(cfg_index) < NUM_COUNTS)
                poly_len[cfg_index] = cfg_data[COUNT_W-1:0];

            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_classes.size() == 0)
                    flag_bad("particle_class beat with none pending", -1,
                             int'(out_ch.particle_class));
                else
                begin
                    want = pending_classes.pop_front();
                    if (out_ch.particle_class !== want)
                        flag_bad("particle_class", int'(want), int'(out_ch.particle_class));
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.cmd == CMD_LOAD)
                begin
                    if (int'(in_ch.polygon_sel) < NUM_POLYGONS &&
                        int'(in_ch.vertex_index) < MAX_VERTICES)
                        vertex_ram[int'(in_ch.polygon_sel) * MAX_VERTICES +
                                   int'(in_ch.vertex_index)] =
                            {in_ch.vertex_stop, in_ch.vertex_thin};
                end
                else
                    pending_classes.push_back(classify_hit(in_ch.alt_set,
                                                           in_ch.stop_energy,
                                                           in_ch.thin_energy));
            end

            classes_due <= pending_classes.size();
            fail_count  <= errs;
        end
    end

endmodule

[verif/polygon_cut_particle_classifier_unit_tb.sv]
// Testbench top: clock, reset, polygon loads, hit stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module polygon_cut_particle_classifier_unit_tb;
    import pcpc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int PHASE_ITEMS   = 40;
    localparam int RANDOM_TARGET = 600;
    localparam int E_MAX         = 65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_N_PROTON,
        REG_N_DEUTERON,
        REG_N_TRITON,
        REG_A_PROTON,
        REG_A_DEUTERON,
        REG_A_TRITON,
        REG_SPARE6,
        REG_SPARE7
    } count_reg_e;

    typedef struct packed {
        logic                cmd;
        logic                alt_set;
        logic [ENERGY_W-1:0] stop_energy;
        logic [ENERGY_W-1:0] thin_energy;
        logic [2:0]          polygon_sel;
        logic [4:0]          vertex_index;
        logic [ENERGY_W-1:0] vertex_stop;
        logic [ENERGY_W-1:0] vertex_thin;
    } hit_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  rx_ready = 1'b0;
    int                    rx_mode = 0;
    int                    rx_left = 0;
    int                    rx_tick = 0;
    int                    cycle_count = 0;
    int                    classes_due;
    int                    fail_count;

    logic [COUNT_W-1:0]  vcount [NUM_COUNTS];
    int                  cen_x [NUM_POLYGONS];
    int                  cen_y [NUM_POLYGONS];
    int                  spread [NUM_POLYGONS];
    logic [ENERGY_W-1:0] shadow_x [NUM_POLYGONS][MAX_VERTICES];
    logic [ENERGY_W-1:0] shadow_y [NUM_POLYGONS][MAX_VERTICES];
    int                  burst_left = 0;
    bit                  valid_hi = 1'b0;
    int                  random_items = 0;

    pcpc_in_if  in_ch ();
    pcpc_out_if out_ch ();

    assign out_ch.ready = rx_ready;

    polygon_cut_particle_classifier_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    pcpc_class_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .classes_due (classes_due),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // output side: stall pattern switches among four modes
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 300);
        end
        else
            rx_left <= rx_left - 1;
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0: rx_ready <= 1'b1;
            1: rx_ready <= 1'($urandom_range(0, 1));
            2: rx_ready <= (rx_tick % 4 == 0);
            default: rx_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    function automatic logic [ENERGY_W-1:0] clamp16(int v);
        if (v < 0)
            return '0;
        if (v > E_MAX)
            return 16'hFFFF;
        return v[ENERGY_W-1:0];
    endfunction

    function automatic int span_rand(int s);
        return int'($urandom_range(0, 2 * s)) - s;
    endfunction

    function automatic int live_count(int p);
        return (int'(vcount[p]) > MAX_VERTICES) ? MAX_VERTICES : int'(vcount[p]);
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return '0;
        if (r == 2)
            return COUNT_W'($urandom_range(1, 2));
        if (r < 5)
            return COUNT_W'($urandom_range(32, 63));
        return COUNT_W'($urandom_range(3, 19));
    endfunction

    function automatic hit_beat_t rand_beat();
        hit_beat_t b;
        b.cmd          = 1'($urandom);
        b.alt_set      = 1'($urandom);
        b.stop_energy  = ENERGY_W'($urandom);
        b.thin_energy  = ENERGY_W'($urandom);
        b.polygon_sel  = 3'($urandom);
        b.vertex_index = 5'($urandom);
        b.vertex_stop  = ENERGY_W'($urandom);
        b.vertex_thin  = ENERGY_W'($urandom);
        return b;
    endfunction

    task automatic send_beat(input hit_beat_t b);
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= b.cmd;
        in_ch.alt_set      <= b.alt_set;
        in_ch.stop_energy  <= b.stop_energy;
        in_ch.thin_energy  <= b.thin_energy;
        in_ch.polygon_sel  <= b.polygon_sel;
        in_ch.vertex_index <= b.vertex_index;
        in_ch.vertex_stop  <= b.vertex_stop;
        in_ch.vertex_thin  <= b.vertex_thin;
        valid_hi = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_ch.valid <= 1'b0;
            valid_hi = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic load_vertex(input int sel, input int idx, input logic [ENERGY_W-1:0] x,
                               input logic [ENERGY_W-1:0] y);
        hit_beat_t b;
        b = rand_beat();
        b.cmd          = CMD_LOAD;
        b.polygon_sel  = 3'(sel);
        b.vertex_index = 5'(idx);
        b.vertex_stop  = x;
        b.vertex_thin  = y;
        if (sel < NUM_POLYGONS)
        begin
            shadow_x[sel][idx] = x;
            shadow_y[sel][idx] = y;
        end
        send_beat(b);
    endtask

    task automatic classify_point(input logic alt, input logic [ENERGY_W-1:0] x,
                                  input logic [ENERGY_W-1:0] y);
        hit_beat_t b;
        b = rand_beat();
        b.cmd         = CMD_CLASSIFY;
        b.alt_set     = alt;
        b.stop_energy = x;
        b.thin_energy = y;
        send_beat(b);
    endtask

    // wait until every class is out and the block has settled, with valid low
    task automatic drain();
        if (valid_hi)
        begin
            in_ch.valid <= 1'b0;
            valid_hi = 1'b0;
        end
        @(posedge clk);
        while (classes_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input count_reg_e r, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic write_counts();
        for (int r = 0; r < NUM_COUNTS; r++)
            cfg_write(count_reg_e'(r), CFG_DATA_W'(vcount[r]));
        if ($urandom_range(0, 1) == 0)
            cfg_write(REG_SPARE6, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 1) == 0)
            cfg_write(REG_SPARE7, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // jittered ring around a random center; wide rings clip to the axis limits
    task automatic place_polygon(input int p);
        int n;
        real ang;
        real rr;
        n = live_count(p);
        if (n == 0)
            return;
        cen_x[p]  = $urandom_range(4000, 61000);
        cen_y[p]  = $urandom_range(4000, 61000);
        spread[p] = ($urandom_range(0, 7) == 0) ? 40000 : $urandom_range(300, 6000);
        for (int i = 0; i < n; i++)
        begin
            ang = 6.2831853 * i / n;
            rr  = spread[p] * (0.55 + 0.45 * $urandom_range(0, 1000) / 1000.0);
            load_vertex(p, i, clamp16(cen_x[p] + $rtoi(rr * $cos(ang))),
                        clamp16(cen_y[p] + $rtoi(rr * $sin(ang))));
            random_items++;
        end
    endtask

    task automatic random_item();
        int p;
        int n;
        int i;
        int pick;
        logic alt;
        logic [ENERGY_W-1:0] x, y;
        random_items++;
        if ($urandom_range(0, 99) < 65)
        begin
            alt  = 1'($urandom_range(0, 1));
            p    = (alt ? int'(ALT_BASE) : 0) + $urandom_range(0, 2);
            n    = live_count(p);
            pick = $urandom_range(0, 9);
            x    = ENERGY_W'($urandom);
            y    = ENERGY_W'($urandom);
            if (pick < 6)
            begin
                x = clamp16(cen_x[p] + span_rand(spread[p] * 13 / 10));
                y = clamp16(cen_y[p] + span_rand(spread[p] * 13 / 10));
            end
            else if (pick < 8 && n > 0)
            begin
                i = $urandom_range(0, n - 1);
                y = shadow_y[p][i];
                if (pick == 6)
                    x = shadow_x[p][i];
            end
            classify_point(alt, x, y);
        end
        else
        begin
            p = $urandom_range(0, NUM_POLYGONS - 1);
            n = live_count(p);
            if ($urandom_range(0, 3) != 0 && n > 0)
            begin
                i = $urandom_range(0, n - 1);
                load_vertex(p, i, clamp16(shadow_x[p][i] + span_rand(spread[p] / 4)),
                            clamp16(shadow_y[p][i] + span_rand(spread[p] / 4)));
            end
            else
                load_vertex($urandom_range(0, 7), $urandom_range(0, MAX_VERTICES - 1),
                            ENERGY_W'($urandom), ENERGY_W'($urandom));
        end
    endtask

    initial
    begin
        int phase;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.cmd          <= CMD_LOAD;
        in_ch.alt_set      <= 1'b0;
        in_ch.stop_energy  <= '0;
        in_ch.thin_energy  <= '0;
        in_ch.polygon_sel  <= '0;
        in_ch.vertex_index <= '0;
        in_ch.vertex_stop  <= '0;
        in_ch.vertex_thin  <= '0;
        for (int p = 0; p < NUM_POLYGONS; p++)
        begin
            cen_x[p]  = 32768;
            cen_y[p]  = 32768;
            spread[p] = 2000;
        end
        for (int r = 0; r < NUM_COUNTS; r++)
            vcount[r] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty polygons after reset, and loads to polygons that do not exist
        classify_point(1'b0, 16'h0000, 16'h0000);
        classify_point(1'b1, 16'hFFFF, 16'hFFFF);
        load_vertex(6, MAX_VERTICES - 1, 16'hFFFF, 16'hFFFF);
        load_vertex(7, 0, 16'h0000, 16'h0000);
        drain();

        // full-range triangle, single-vertex and two-vertex polygons
        vcount = '{6'd3, 6'd1, 6'd2, 6'd0, 6'd0, 6'd0};
        write_counts();
        load_vertex(0, 0, 16'h0000, 16'h0000);
        load_vertex(0, 1, 16'hFFFF, 16'h8000);
        load_vertex(0, 2, 16'h0000, 16'hFFFF);
        load_vertex(1, 0, 16'd1000, 16'd1000);
        load_vertex(2, 0, 16'h0000, 16'h0000);
        load_vertex(2, 1, 16'hFFFF, 16'hFFFF);
        classify_point(1'b0, 16'd1000, 16'h8000);
        classify_point(1'b0, 16'hFFFF, 16'hFFFF);
        classify_point(1'b0, 16'h0000, 16'h0000);
        classify_point(1'b0, 16'hFFFF, 16'h8000);
        classify_point(1'b0, 16'd20000, 16'hFFFF);
        classify_point(1'b0, 16'd1000, 16'd1000);
        classify_point(1'b1, 16'd30000, 16'd30000);

        phase = 0;
        while (random_items < RANDOM_TARGET)
        begin
            drain();
            case (phase)
                0: vcount = '{6'd32, 6'd63, 6'd40, 6'd0, 6'd3, 6'd19};
                1: vcount = '{6'd2, 6'd1, 6'd0, 6'd63, 6'd32, 6'd17};
                default:
                    for (int r = 0; r < NUM_COUNTS; r++)
                        vcount[r] = pick_count();
            endcase
            write_counts();
            for (int p = 0; p < NUM_POLYGONS; p++)
                place_polygon(p);
            repeat (PHASE_ITEMS) random_item();
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
hdl/pcpc_pkg.sv
hdl/pcpc_if.sv
hdl/polygon_cut_particle_classifier_unit.sv
hdl/pcpc_checker.sv
verif/pcpc_class_checker.sv
verif/polygon_cut_particle_classifier_unit_tb.sv
